// ----- rtl/core/lxu_pkg.sv -----
// ----------------------------------------------------------------------------
// lxu_pkg: shared types and constants of the linear extension unrank unit
// Command and status groups between controller and datapath, state and
// status encodings, item kinds and register indexes.
// ----------------------------------------------------------------------------
package lxu_pkg;

   localparam int unsigned COUNT_W = 48;
   localparam int unsigned LABEL_W = 16;

   localparam logic [1:0] KIND_SLOT  = 2'd0;
   localparam logic [1:0] KIND_COUNT = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [1:0] CSR_EXT_COUNT = 2'd0;
   localparam logic [1:0] CSR_EXT_WIDTH = 2'd1;
   localparam logic [1:0] CSR_NBR_SLOTS = 2'd2;

   localparam logic [4:0] EXT_WIDTH_RESET = 5'd16;
   localparam logic [3:0] NBR_SLOTS_RESET = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RANGE,
      ST_SCAN,
      ST_MATCH,
      ST_DEAD
   } state_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_DEAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic       wr_slot;
      logic       wr_count;
      logic       query_start;
      logic       level_init;
      logic       scan;
      logic       advance;
      logic       pos_dec;
      logic       out_load;
      status_type out_status;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic hit;
      logic miss;
      logic lab_zero;
      logic pos_zero;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/core/lxu_if.sv -----
// ----------------------------------------------------------------------------
// lxu_if: item channels of the linear extension unrank unit
// Request channel (loads and queries) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface lxu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [9:0]  node;
   logic [2:0]  slot;
   logic        slot_valid;
   logic [9:0]  target_node;
   logic [15:0] edge_label;
   logic [47:0] path_count;
   logic [47:0] rank;

   modport source (
      output valid, kind, node, slot, slot_valid, target_node, edge_label,
             path_count, rank,
      input  ready
   );
   modport sink (
      input  valid, kind, node, slot, slot_valid, target_node, edge_label,
             path_count, rank,
      output ready
   );
endinterface

interface lxu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] label;
   logic [3:0]  position;
   logic [1:0]  status;
   logic        last;

   modport source (
      output valid, label, position, status, last,
      input  ready
   );
   modport sink (
      input  valid, label, position, status, last,
      output ready
   );
endinterface

// ----- rtl/core/lxu_csr.sv -----
// ----------------------------------------------------------------------------
// lxu_csr: configuration registers
// APB-style write/read of extension count, extension width and neighbor
// slot count; width and slot count leave here clamped to their legal range.
// ----------------------------------------------------------------------------
module lxu_csr #(
   parameter int MAX_SLOTS = 8,
   parameter int MAX_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [4:0]                         paddr,
   input  logic [63:0]                        pwdata,
   output logic [63:0]                        prdata,
   output logic                               pready,
   output logic [47:0]                        ext_count,
   output logic [$clog2(MAX_WIDTH + 1)-1:0]   width_sat,
   output logic [$clog2(MAX_SLOTS + 1)-1:0]   nslots_sat
);

   localparam int PW  = $clog2(MAX_WIDTH + 1);
   localparam int SCW = $clog2(MAX_SLOTS + 1);

   logic [47:0] ext_count_ff, ext_count_in;
   logic [4:0]  ext_width_ff, ext_width_in;
   logic [3:0]  nbr_slots_ff, nbr_slots_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:3];

   always_comb begin
      ext_count_in = ext_count_ff;
      ext_width_in = ext_width_ff;
      nbr_slots_in = nbr_slots_ff;
      if (wr_en) begin
         case (reg_idx)
            lxu_pkg::CSR_EXT_COUNT: ext_count_in = pwdata[47:0];
            lxu_pkg::CSR_EXT_WIDTH: ext_width_in = pwdata[4:0];
            lxu_pkg::CSR_NBR_SLOTS: nbr_slots_in = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_count_ff <= '0;
         ext_width_ff <= lxu_pkg::EXT_WIDTH_RESET;
         nbr_slots_ff <= lxu_pkg::NBR_SLOTS_RESET;
      end else begin
         ext_count_ff <= ext_count_in;
         ext_width_ff <= ext_width_in;
         nbr_slots_ff <= nbr_slots_in;
      end
   end

   always_comb begin
      case (reg_idx)
         lxu_pkg::CSR_EXT_COUNT: prdata = {16'd0, ext_count_ff};
         lxu_pkg::CSR_EXT_WIDTH: prdata = {59'd0, ext_width_ff};
         lxu_pkg::CSR_NBR_SLOTS: prdata = {60'd0, nbr_slots_ff};
         default:                prdata = '0;
      endcase
   end

   always_comb begin
      if (ext_width_ff == '0) begin
         width_sat = PW'(1);
      end else if (32'(ext_width_ff) > 32'(MAX_WIDTH)) begin
         width_sat = PW'(MAX_WIDTH);
      end else begin
         width_sat = PW'(ext_width_ff);
      end
   end

   always_comb begin
      if (nbr_slots_ff == '0) begin
         nslots_sat = SCW'(1);
      end else if (32'(nbr_slots_ff) > 32'(MAX_SLOTS)) begin
         nslots_sat = SCW'(MAX_SLOTS);
      end else begin
         nslots_sat = SCW'(nbr_slots_ff);
      end
   end

   assign ext_count = ext_count_ff;

endmodule

// ----- rtl/core/lxu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lxu_ctrl: query sequencer
// Takes request items, starts loads and queries, steps the walk level by
// level and hands each result to the output register.
// ----------------------------------------------------------------------------
module lxu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_kind,
   output logic                   req_ready,
   input  lxu_pkg::dp_status_type status,
   output lxu_pkg::cmd_type       cmd
);

   lxu_pkg::state_type state_ff, state_in;
   logic               accept;

   assign accept = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lxu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lxu_pkg::ST_IDLE: begin
            if (accept && req_kind == lxu_pkg::KIND_QUERY) begin
               state_in = lxu_pkg::ST_CHECK;
            end
         end
         lxu_pkg::ST_CHECK: begin
            state_in = status.oor ? lxu_pkg::ST_RANGE : lxu_pkg::ST_SCAN;
         end
         lxu_pkg::ST_RANGE: begin
            if (status.out_free && status.pos_zero) begin
               state_in = lxu_pkg::ST_IDLE;
            end
         end
         lxu_pkg::ST_SCAN: begin
            if (status.hit) begin
               state_in = lxu_pkg::ST_MATCH;
            end else if (status.miss) begin
               state_in = lxu_pkg::ST_DEAD;
            end
         end
         lxu_pkg::ST_MATCH: begin
            if (status.lab_zero) begin
               state_in = lxu_pkg::ST_DEAD;
            end else if (status.out_free) begin
               state_in = status.pos_zero ? lxu_pkg::ST_IDLE : lxu_pkg::ST_SCAN;
            end
         end
         lxu_pkg::ST_DEAD: begin
            if (status.out_free) begin
               state_in = lxu_pkg::ST_IDLE;
            end
         end
         default: state_in = lxu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.out_status = lxu_pkg::STATUS_OK;
      case (state_ff)
         lxu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               case (req_kind)
                  lxu_pkg::KIND_SLOT:  cmd.wr_slot     = 1'b1;
                  lxu_pkg::KIND_COUNT: cmd.wr_count    = 1'b1;
                  lxu_pkg::KIND_QUERY: cmd.query_start = 1'b1;
                  default: ;
               endcase
            end
         end
         lxu_pkg::ST_CHECK: begin
            cmd.level_init = 1'b1;
         end
         lxu_pkg::ST_RANGE: begin
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = lxu_pkg::STATUS_RANGE;
               cmd.out_last   = status.pos_zero;
               cmd.pos_dec    = ~status.pos_zero;
            end
         end
         lxu_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         lxu_pkg::ST_MATCH: begin
            if (!status.lab_zero && status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = lxu_pkg::STATUS_OK;
               cmd.out_last   = status.pos_zero;
               cmd.advance    = ~status.pos_zero;
            end
         end
         lxu_pkg::ST_DEAD: begin
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = lxu_pkg::STATUS_DEAD;
               cmd.out_last   = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/lxu_dp.sv -----
// ----------------------------------------------------------------------------
// lxu_dp: walk datapath
// Slot and count memories, a two-stage slot scan pipeline with interval
// compare, walk registers (rank, node, position) and the result register.
// ----------------------------------------------------------------------------
module lxu_dp #(
   parameter int NODE_COUNT = 1024,
   parameter int MAX_SLOTS  = 8,
   parameter int MAX_WIDTH  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lxu_pkg::cmd_type                   cmd,
   output lxu_pkg::dp_status_type             status,
   input  logic [9:0]                         req_node,
   input  logic [2:0]                         req_slot,
   input  logic                               req_slot_valid,
   input  logic [9:0]                         req_target_node,
   input  logic [15:0]                        req_edge_label,
   input  logic [47:0]                        req_path_count,
   input  logic [47:0]                        req_rank,
   input  logic [47:0]                        ext_count,
   input  logic [$clog2(MAX_WIDTH + 1)-1:0]   width_sat,
   input  logic [$clog2(MAX_SLOTS + 1)-1:0]   nslots_sat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [15:0]                        rsp_label,
   output logic [3:0]                         rsp_position,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);

   localparam int NW     = $clog2(NODE_COUNT);
   localparam int SDEPTH = NODE_COUNT * MAX_SLOTS;
   localparam int SAW    = $clog2(SDEPTH);
   localparam int SCW    = $clog2(MAX_SLOTS + 1);
   localparam int PW     = $clog2(MAX_WIDTH + 1);
   localparam int SUMW   = 48 + SCW;
   localparam int EW     = 1 + NW + 16;

   function automatic logic [9:0] wrap_node(input logic [9:0] v);
      logic [31:0] rem;
      rem = 32'(v);
      for (int k = 9; k >= 0; k--) begin
         if (rem >= (32'(NODE_COUNT) << k)) begin
            rem = rem - (32'(NODE_COUNT) << k);
         end
      end
      return rem[9:0];
   endfunction

   logic [EW-1:0] slot_mem [SDEPTH];
   logic [47:0]   cnt_mem  [NODE_COUNT];

   logic [NW-1:0]   wr_node, wr_tgt;
   logic            slot_ok;
   logic [SAW-1:0]  wr_addr, rd_addr;

   logic [EW-1:0]   slot_rd_ff;
   logic [47:0]     cnt_rd_ff;
   logic            s1_vld_ff, s1_vld_in;
   logic            s1_last_ff;
   logic            s2_vld_ff, s2_vld_in;
   logic            s2_last_ff, s2_mark_ff;
   logic [NW-1:0]   s2_tgt_ff;
   logic [15:0]     s2_lab_ff;

   logic [SCW-1:0]  iss_ff, iss_in;
   logic            issue;
   logic [SUMW-1:0] start_ff, start_in, end_sum, rank_ext;
   logic            eval, hit_now, miss_now;

   logic [47:0]     rank_ff, rank_in;
   logic [NW-1:0]   cur_ff, cur_in;
   logic [PW-1:0]   pos_ff, pos_in;

   logic [15:0]     hit_lab_ff;
   logic [NW-1:0]   hit_next_ff;
   logic [47:0]     hit_start_ff;

   logic            out_vld_ff, out_vld_in;
   logic [15:0]     out_lab_ff;
   logic [3:0]      out_pos_ff;
   lxu_pkg::status_type out_status_ff;
   logic            out_last_ff;

   assign wr_node = NW'(wrap_node(req_node));
   assign wr_tgt  = NW'(wrap_node(req_target_node));
   assign slot_ok = 32'(req_slot) < 32'(MAX_SLOTS);
   assign wr_addr = SAW'(wr_node) * SAW'(MAX_SLOTS) + SAW'(req_slot);
   assign rd_addr = SAW'(cur_ff) * SAW'(MAX_SLOTS) + SAW'(iss_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_slot && slot_ok) begin
         slot_mem[wr_addr] <= {req_slot_valid, wr_tgt, req_edge_label};
      end
      slot_rd_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_count) begin
         cnt_mem[wr_node] <= req_path_count;
      end
      cnt_rd_ff <= cnt_mem[slot_rd_ff[16 +: NW]];
   end

   assign issue     = cmd.scan & (iss_ff < nslots_sat);
   assign s1_vld_in = issue;
   assign s2_vld_in = s1_vld_ff & cmd.scan;

   assign rank_ext = SUMW'(rank_ff);
   assign end_sum  = start_ff + SUMW'(cnt_rd_ff);
   assign eval     = cmd.scan & s2_vld_ff & s2_mark_ff;
   assign hit_now  = eval & (cnt_rd_ff != '0) & (rank_ext >= start_ff) & (rank_ext < end_sum);
   assign miss_now = cmd.scan & s2_vld_ff & s2_last_ff & ~hit_now;

   always_comb begin
      iss_in   = iss_ff;
      start_in = start_ff;
      if (cmd.level_init || cmd.advance) begin
         iss_in   = '0;
         start_in = '0;
      end else begin
         if (issue) begin
            iss_in = iss_ff + SCW'(1);
         end
         if (eval && !hit_now) begin
            start_in = end_sum;
         end
      end
   end

   always_comb begin
      rank_in = rank_ff;
      cur_in  = cur_ff;
      pos_in  = pos_ff;
      if (cmd.query_start) begin
         rank_in = req_rank;
         cur_in  = '0;
         pos_in  = width_sat - PW'(1);
      end else begin
         if (cmd.advance) begin
            rank_in = rank_ff - hit_start_ff;
            cur_in  = hit_next_ff;
         end
         if (cmd.advance || cmd.pos_dec) begin
            pos_in = pos_ff - PW'(1);
         end
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         iss_ff     <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         out_vld_ff <= out_vld_in;
         iss_ff     <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= (iss_ff == nslots_sat - SCW'(1));
      s2_last_ff <= s1_last_ff;
      s2_mark_ff <= slot_rd_ff[EW-1];
      s2_tgt_ff  <= slot_rd_ff[16 +: NW];
      s2_lab_ff  <= slot_rd_ff[15:0];
      start_ff   <= start_in;
      rank_ff    <= rank_in;
      cur_ff     <= cur_in;
      pos_ff     <= pos_in;
      if (hit_now) begin
         hit_lab_ff   <= s2_lab_ff;
         hit_next_ff  <= s2_tgt_ff;
         hit_start_ff <= start_ff[47:0];
      end
      if (cmd.out_load) begin
         out_lab_ff    <= (cmd.out_status == lxu_pkg::STATUS_OK) ? hit_lab_ff : '0;
         out_pos_ff    <= 4'(pos_ff);
         out_status_ff <= cmd.out_status;
         out_last_ff   <= cmd.out_last;
      end
   end

   assign status.oor      = rank_ff >= ext_count;
   assign status.hit      = hit_now;
   assign status.miss     = miss_now;
   assign status.lab_zero = hit_lab_ff == '0;
   assign status.pos_zero = pos_ff == '0;
   assign status.out_free = ~out_vld_ff | rsp_ready;

   assign rsp_valid    = out_vld_ff;
   assign rsp_label    = out_lab_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last     = out_last_ff;

endmodule

// ----- rtl/core/linear_extension_unrank_unit.sv -----
// ----------------------------------------------------------------------------
// linear_extension_unrank_unit: ranked walk through a lattice-of-ideals graph
// Load items fill the neighbor slot and path count tables; a query item
// returns the labels of the linear extension with the given rank.
// ----------------------------------------------------------------------------
// A load item gives no result. A query gives one result
// per level, positions counting down from the extension width minus one,
// with last set on the final one; an out-of-range rank gives width results
// with label 0, and a dead end stops the run with one label-0 result. The
// walk scans one neighbor slot per cycle through the slot memory and then
// the count memory. The tables hold no reset value: every entry a query
// reaches must have been loaded. The next request is taken while the final
// result of a query still waits.
module linear_extension_unrank_unit #(
   parameter int NODE_COUNT = 1024,
   parameter int MAX_SLOTS  = 8,
   parameter int MAX_WIDTH  = 16
) (
   input  logic         clock,
   input  logic         reset,
   lxu_req_if.sink      req_bus,
   lxu_rsp_if.source    rsp_bus,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [63:0]  pwdata,
   output logic [63:0]  prdata,
   output logic         pready
);

   localparam int PW  = $clog2(MAX_WIDTH + 1);
   localparam int SCW = $clog2(MAX_SLOTS + 1);

   lxu_pkg::cmd_type       cmd;
   lxu_pkg::dp_status_type status;
   logic [47:0]            ext_count;
   logic [PW-1:0]          width_sat;
   logic [SCW-1:0]         nslots_sat;
   logic                   req_ready;

   assign req_bus.ready = req_ready;

   lxu_csr #(
      .MAX_SLOTS (MAX_SLOTS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .ext_count  (ext_count),
      .width_sat  (width_sat),
      .nslots_sat (nslots_sat)
   );

   lxu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lxu_dp #(
      .NODE_COUNT (NODE_COUNT),
      .MAX_SLOTS  (MAX_SLOTS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_node        (req_bus.node),
      .req_slot        (req_bus.slot),
      .req_slot_valid  (req_bus.slot_valid),
      .req_target_node (req_bus.target_node),
      .req_edge_label  (req_bus.edge_label),
      .req_path_count  (req_bus.path_count),
      .req_rank        (req_bus.rank),
      .ext_count       (ext_count),
      .width_sat       (width_sat),
      .nslots_sat      (nslots_sat),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_label       (rsp_bus.label),
      .rsp_position    (rsp_bus.position),
      .rsp_status      (rsp_bus.status),
      .rsp_last        (rsp_bus.last)
   );

endmodule

// ----- rtl/core/lxu_checker.sv -----
// ----------------------------------------------------------------------------
// lxu_checker: port-level checks of the linear extension unrank unit
// Result channel hold, reset behavior and consistency of result fields.
// ----------------------------------------------------------------------------
module lxu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_label,
   input logic [3:0]  rsp_position,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_label)
         && $stable(rsp_position) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_fail_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lxu_pkg::STATUS_RANGE
         || rsp_status == lxu_pkg::STATUS_DEAD) |-> rsp_label == '0)
      else $error("failed result carries a label");

   a_dead_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lxu_pkg::STATUS_DEAD |-> rsp_last)
      else $error("dead end result not marked last");

   a_ok_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lxu_pkg::STATUS_OK && rsp_last |-> rsp_position == '0)
      else $error("final label not at position zero");

endmodule

bind linear_extension_unrank_unit lxu_checker u_lxu_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_label    (rsp_bus.label),
   .rsp_position (rsp_bus.position),
   .rsp_status   (rsp_bus.status),
   .rsp_last     (rsp_bus.last)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the linear extension unrank unit
// Loads small layered ideal lattices into the slot and count tables and
// queries ranks across them, at several register settings. A scoreboard
// keeps its own copy of the tables and registers, walks each accepted query
// the same way the unit does, and checks every result item in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0]                  KIND_SPARE  = 2'd3;
   localparam logic [lxu_pkg::COUNT_W-1:0] COUNT_MAX   = '1;
   localparam int                          ITEM_TARGET = 180;
   localparam int                          SLOT_LIMIT  = 8;
   localparam int                          WIDTH_LIMIT = 16;

   typedef struct {
      logic [1:0]                  kind;
      logic [9:0]                  node;
      logic [2:0]                  slot;
      logic                        slot_valid;
      logic [9:0]                  target_node;
      logic [15:0]                 edge_label;
      logic [lxu_pkg::COUNT_W-1:0] path_count;
      logic [lxu_pkg::COUNT_W-1:0] rank;
   } lxu_item_type;

   typedef struct {
      logic [15:0] label;
      logic [3:0]  position;
      logic [1:0]  status;
      logic        last;
   } lxu_result_type;

   class ideal_walk_tracker;
      logic                        slot_on   [1024*SLOT_LIMIT];
      logic [9:0]                  slot_dest [1024*SLOT_LIMIT];
      logic [15:0]                 slot_tag  [1024*SLOT_LIMIT];
      bit                          slot_set  [1024*SLOT_LIMIT];
      logic [lxu_pkg::COUNT_W-1:0] node_paths[1024];
      bit                          node_set  [1024];
      logic [lxu_pkg::COUNT_W-1:0] ext_count;
      logic [4:0]                  ext_width;
      logic [3:0]                  nbr_slots;
      lxu_result_type              walk_labels[$];
      lxu_result_type              due_labels[$];
      int                          errors;
      int                          checked;
      int                          range_seen;
      int                          dead_seen;

      function new();
         foreach (slot_on[i]) begin
            slot_on[i]  = 1'b0;
            slot_dest[i] = '0;
            slot_tag[i] = '0;
            slot_set[i] = 1'b0;
         end
         foreach (node_paths[i]) begin
            node_paths[i] = '0;
            node_set[i]   = 1'b0;
         end
         ext_count = '0;
         ext_width = lxu_pkg::EXT_WIDTH_RESET;
         nbr_slots = lxu_pkg::NBR_SLOTS_RESET;
         errors = 0;
         checked = 0;
         range_seen = 0;
         dead_seen = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [63:0] value);
         case (idx)
            lxu_pkg::CSR_EXT_COUNT: ext_count = value[lxu_pkg::COUNT_W-1:0];
            lxu_pkg::CSR_EXT_WIDTH: ext_width = value[4:0];
            lxu_pkg::CSR_NBR_SLOTS: nbr_slots = value[3:0];
            default: ;
         endcase
      endfunction

      function int levels();
         if (ext_width == 0) return 1;
         if (ext_width > WIDTH_LIMIT) return WIDTH_LIMIT;
         return int'(ext_width);
      endfunction

      function int scan_slots();
         if (nbr_slots == 0) return 1;
         if (nbr_slots > SLOT_LIMIT) return SLOT_LIMIT;
         return int'(nbr_slots);
      endfunction

      function void push_label(logic [15:0] label, int pos, logic [1:0] status, logic last);
         lxu_result_type r;
         r.label = label;
         r.position = pos[3:0];
         r.status = status;
         r.last = last;
         walk_labels.push_back(r);
      endfunction

      // Walk the lattice for one rank into walk_labels; report unloaded reads.
      function bit unrank_walk(logic [lxu_pkg::COUNT_W-1:0] rank_in);
         int          w;
         int          ns;
         int          pos;
         int          s;
         int          a;
         logic [63:0] rest;
         logic [63:0] start;
         logic [63:0] cnt;
         logic [9:0]  here;
         logic [9:0]  nxt;
         logic [9:0]  tn;
         logic [15:0] lab;
         bit          hit;
         bit          blind;
         walk_labels.delete();
         blind = 1'b0;
         w = levels();
         ns = scan_slots();
         if (rank_in >= ext_count) begin
            for (pos = w - 1; pos >= 0; pos--)
               push_label('0, pos, lxu_pkg::STATUS_RANGE, pos == 0);
            return 1'b0;
         end
         rest = 64'(rank_in);
         here = '0;
         for (pos = w - 1; pos >= 0; pos--) begin
            hit = 1'b0;
            start = '0;
            lab = '0;
            nxt = '0;
            for (s = 0; s < ns && !hit; s++) begin
               a = here * SLOT_LIMIT + s;
               if (!slot_set[a]) blind = 1'b1;
               if (slot_on[a]) begin
                  tn = slot_dest[a];
                  if (!node_set[tn]) blind = 1'b1;
                  cnt = 64'(node_paths[tn]);
                  if (cnt != 0 && rest >= start && rest - start < cnt) begin
                     hit = 1'b1;
                     lab = slot_tag[a];
                     nxt = tn;
                  end else begin
                     start += cnt;
                  end
               end
            end
            if (!hit || lab == 0) begin
               push_label('0, pos, lxu_pkg::STATUS_DEAD, 1'b1);
               return blind;
            end
            push_label(lab, pos, lxu_pkg::STATUS_OK, pos == 0);
            rest -= start;
            here = nxt;
         end
         return blind;
      endfunction

      function void note_item(lxu_item_type it);
         int a;
         a = it.node * SLOT_LIMIT + it.slot;
         case (it.kind)
            lxu_pkg::KIND_SLOT: begin
               slot_on[a]   = it.slot_valid;
               slot_dest[a] = it.target_node;
               slot_tag[a]  = it.edge_label;
               slot_set[a]  = 1'b1;
            end
            lxu_pkg::KIND_COUNT: begin
               node_paths[it.node] = it.path_count;
               node_set[it.node]   = 1'b1;
            end
            lxu_pkg::KIND_QUERY: begin
               void'(unrank_walk(it.rank));
               foreach (walk_labels[i]) due_labels.push_back(walk_labels[i]);
            end
            default: ;
         endcase
      endfunction

      function void check_label(logic [15:0] label, logic [3:0] position,
                                logic [1:0] status, logic last);
         lxu_result_type want;
         if (due_labels.size() == 0) begin
            $error("unexpected item: label %0h position %0d status %0d last %0b",
                   label, position, status, last);
            errors++;
            return;
         end
         want = due_labels.pop_front();
         checked++;
         if (want.status == lxu_pkg::STATUS_RANGE) range_seen++;
         if (want.status == lxu_pkg::STATUS_DEAD) dead_seen++;
         if (label !== want.label) begin
            $error("label: expected %0h, got %0h", want.label, label);
            errors++;
         end
         if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   lxu_req_if req_bus ();
   lxu_rsp_if rsp_bus ();

   ideal_walk_tracker tracker = new();

   int sender_idle;
   int receiver_idle;
   int queries_sent;
   int loads_sent;
   int spare_sent;
   int items_sent;
   int phases;
   int graph_nodes[$];

   linear_extension_unrank_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         tracker.check_label(rsp_bus.label, rsp_bus.position, rsp_bus.status, rsp_bus.last);
   end

   initial begin
      #8000000;
      $display("run timed out with %0d items still due", tracker.due_labels.size());
      $display("TB_ERROR");
      $finish;
   end

   function automatic lxu_item_type noise_item(logic [1:0] kind);
      lxu_item_type it;
      it.kind        = kind;
      it.node        = 10'($urandom);
      it.slot        = 3'($urandom);
      it.slot_valid  = 1'($urandom);
      it.target_node = 10'($urandom);
      it.edge_label  = 16'($urandom);
      it.path_count  = 48'({$urandom, $urandom});
      it.rank        = 48'({$urandom, $urandom});
      return it;
   endfunction

   function automatic lxu_item_type slot_item(logic [9:0] node, logic [2:0] slot, logic on,
                                              logic [9:0] dest, logic [15:0] label);
      lxu_item_type it;
      it = noise_item(lxu_pkg::KIND_SLOT);
      it.node = node;
      it.slot = slot;
      it.slot_valid = on;
      it.target_node = dest;
      it.edge_label = label;
      return it;
   endfunction

   function automatic lxu_item_type count_item(logic [9:0] node,
                                               logic [lxu_pkg::COUNT_W-1:0] paths);
      lxu_item_type it;
      it = noise_item(lxu_pkg::KIND_COUNT);
      it.node = node;
      it.path_count = paths;
      return it;
   endfunction

   function automatic lxu_item_type query_item(logic [lxu_pkg::COUNT_W-1:0] rank);
      lxu_item_type it;
      it = noise_item(lxu_pkg::KIND_QUERY);
      it.rank = rank;
      return it;
   endfunction

   task automatic set_mode(int m);
      sender_idle   = (m == 0) ? 31 : (m == 1) ? 57 : 0;
      receiver_idle = (m == 0) ? 57 : (m == 1) ? 31 : 0;
   endtask

   task automatic send_item(lxu_item_type it);
      if ($urandom_range(0, 99) < sender_idle) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= it.kind;
      req_bus.node        <= it.node;
      req_bus.slot        <= it.slot;
      req_bus.slot_valid  <= it.slot_valid;
      req_bus.target_node <= it.target_node;
      req_bus.edge_label  <= it.edge_label;
      req_bus.path_count  <= it.path_count;
      req_bus.rank        <= it.rank;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_item(it);
      items_sent++;
      case (it.kind)
         lxu_pkg::KIND_QUERY: queries_sent++;
         KIND_SPARE:          spare_sent++;
         default:             loads_sent++;
      endcase
   endtask

   // Drop valid, wait for every due item, then let the unit go quiet.
   task automatic settle(int pause);
      req_bus.valid <= 1'b0;
      while (tracker.due_labels.size() != 0) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      tracker.set_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Load a layered lattice rooted at node 0, counts consistent bottom up.
   task automatic build_lattice(input bit big,
                                output logic [lxu_pkg::COUNT_W-1:0] root_total);
      int                          level_size [WIDTH_LIMIT+1];
      int                          level_node [WIDTH_LIMIT+1][3];
      bit                          taken [1024];
      logic [lxu_pkg::COUNT_W-1:0] totals [1024];
      logic [63:0]                 sum;
      int                          w;
      int                          ns;
      int                          id;
      int                          d;
      int                          k;
      int                          s;
      int                          tgt;
      bit                          on;
      w = tracker.levels();
      ns = tracker.scan_slots();
      foreach (taken[i]) taken[i] = 1'b0;
      graph_nodes.delete();
      taken[0] = 1'b1;
      level_size[0] = 1;
      level_node[0][0] = 0;
      graph_nodes.push_back(0);
      for (d = 1; d <= w; d++) begin
         level_size[d] = (w * ns >= 16) ? 1 : $urandom_range(1, 3);
         for (k = 0; k < level_size[d]; k++) begin
            do id = $urandom_range(1, 1023); while (taken[id]);
            taken[id] = 1'b1;
            level_node[d][k] = id;
            graph_nodes.push_back(id);
         end
      end
      for (k = 0; k < level_size[w]; k++) begin
         id = level_node[w][k];
         if ($urandom_range(0, 9) == 0)
            totals[id] = '0;
         else if (big)
            totals[id] = 48'((64'($urandom_range(0, 255)) << 32) | 64'($urandom));
         else
            totals[id] = 48'($urandom_range(1, 3));
         send_item(count_item(10'(id), totals[id]));
      end
      for (d = w - 1; d >= 0; d--) begin
         for (k = 0; k < level_size[d]; k++) begin
            id = level_node[d][k];
            sum = '0;
            for (s = 0; s < ns; s++) begin
               on = (s == 0) || ($urandom_range(0, 99) < 70);
               tgt = level_node[d+1][$urandom_range(0, level_size[d+1] - 1)];
               send_item(slot_item(10'(id), 3'(s), on, 10'(tgt),
                         ($urandom_range(0, 29) == 0) ? 16'h0 : 16'($urandom_range(1, 65535))));
               if (on) sum += 64'(totals[tgt]);
            end
            totals[id] = (sum > 64'(COUNT_MAX)) ? COUNT_MAX : sum[lxu_pkg::COUNT_W-1:0];
            send_item(count_item(10'(id), totals[id]));
         end
      end
      root_total = totals[0];
   endtask

   initial begin : stimulus
      logic [4:0]                  width_pick [5];
      logic [3:0]                  slots_pick [5];
      logic [lxu_pkg::COUNT_W-1:0] total;
      logic [lxu_pkg::COUNT_W-1:0] limit;
      logic [lxu_pkg::COUNT_W-1:0] rank;
      logic [63:0]                 wide;
      logic [4:0]                  raw_width;
      logic [3:0]                  raw_slots;
      lxu_item_type                it;
      int                          n;
      int                          r;
      int                          q;
      width_pick = '{5'd0, 5'd1, 5'd17, 5'd3, 5'd31};
      slots_pick = '{4'd15, 4'd0, 4'd1, 4'd9, 4'd2};
      queries_sent = 0;
      loads_sent = 0;
      spare_sent = 0;
      items_sent = 0;
      phases = 0;
      set_mode(0);
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= lxu_pkg::KIND_SLOT;
      req_bus.node        <= '0;
      req_bus.slot        <= '0;
      req_bus.slot_valid  <= 1'b0;
      req_bus.target_node <= '0;
      req_bus.edge_label  <= '0;
      req_bus.path_count  <= '0;
      req_bus.rank        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset registers, then a tiny hand-built lattice.
      send_item(noise_item(KIND_SPARE));
      send_item(query_item('0));
      send_item(query_item(COUNT_MAX));
      settle(10);
      write_csr(lxu_pkg::CSR_EXT_WIDTH, 64'd2);
      write_csr(lxu_pkg::CSR_NBR_SLOTS, 64'd2);
      send_item(count_item(10'd3, 48'd1));
      send_item(count_item(10'd4, 48'd0));
      send_item(count_item(10'd1023, 48'd2));
      send_item(count_item(10'd1, 48'd1));
      send_item(count_item(10'd2, 48'd2));
      send_item(slot_item(10'd0, 3'd0, 1'b1, 10'd1, 16'h0001));
      send_item(slot_item(10'd0, 3'd1, 1'b1, 10'd2, 16'hFFFF));
      send_item(slot_item(10'd1, 3'd0, 1'b0, 10'd1023, 16'h1234));
      send_item(slot_item(10'd1, 3'd1, 1'b1, 10'd3, 16'h8000));
      send_item(slot_item(10'd2, 3'd0, 1'b1, 10'd4, 16'h0005));
      send_item(slot_item(10'd2, 3'd1, 1'b1, 10'd1023, 16'h0000));
      settle(10);
      write_csr(lxu_pkg::CSR_EXT_COUNT, 64'd4);
      for (n = 0; n <= 4; n++) send_item(query_item(48'(n)));

      // Random: one lattice per setting, then queries and noise over it.
      while (items_sent < ITEM_TARGET) begin
         if (phases < 5) begin
            raw_width = width_pick[phases];
            raw_slots = slots_pick[phases];
         end else begin
            raw_width = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                                    : 5'($urandom_range(1, 6));
            raw_slots = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 4));
         end
         phases++;
         settle(10);
         write_csr(lxu_pkg::CSR_EXT_WIDTH, {$urandom, 27'($urandom), raw_width});
         write_csr(lxu_pkg::CSR_NBR_SLOTS, {$urandom, 28'($urandom), raw_slots});
         build_lattice($urandom_range(0, 4) == 0, total);
         r = $urandom_range(0, 9);
         case (r)
            0: limit = '0;
            1: limit = COUNT_MAX;
            2: limit = (total >= COUNT_MAX - 3) ? COUNT_MAX : total + $urandom_range(1, 3);
            3: limit = 48'({$urandom, $urandom});
            default: limit = total;
         endcase
         settle(10);
         write_csr(lxu_pkg::CSR_EXT_COUNT, {16'($urandom), limit});
         n = $urandom_range(6, 12);
         repeat (n) begin
            set_mode((items_sent < ITEM_TARGET / 3) ? 0 :
                     (items_sent < 2 * ITEM_TARGET / 3) ? 1 : 2);
            r = $urandom_range(0, 99);
            if (r < 70 && total != 0) begin
               q = $urandom_range(0, 9);
               wide = {$urandom, $urandom};
               rank = (q == 0) ? '0 : (q == 1) ? total - 1 : 48'(wide % 64'(total));
               it = query_item(rank);
            end else if (r < 80) begin
               wide = 64'(limit) + $urandom_range(0, 2);
               rank = ($urandom_range(0, 3) == 0 || wide > 64'(COUNT_MAX))
                      ? COUNT_MAX : wide[lxu_pkg::COUNT_W-1:0];
               it = query_item(rank);
            end else if (r < 88) begin
               it = slot_item(10'(graph_nodes[$urandom_range(0, graph_nodes.size() - 1)]),
                              3'($urandom), 1'($urandom),
                              10'(graph_nodes[$urandom_range(0, graph_nodes.size() - 1)]),
                              ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom));
            end else if (r < 94) begin
               q = $urandom_range(0, 3);
               it = count_item(10'(graph_nodes[$urandom_range(0, graph_nodes.size() - 1)]),
                               (q == 0) ? '0 : (q == 1) ? COUNT_MAX :
                               (q == 2) ? 48'({$urandom, $urandom}) : 48'($urandom_range(1, 4)));
            end else begin
               it = noise_item(KIND_SPARE);
            end
            // hold tables loaded: steer a walk off unloaded entries out of range
            if (it.kind == lxu_pkg::KIND_QUERY && tracker.unrank_walk(it.rank))
               it.rank = COUNT_MAX;
            send_item(it);
         end
      end

      settle(140);
      $display("covered %0d queries, %0d loads and %0d spare items over %0d settings",
               queries_sent, loads_sent, spare_sent, phases + 1);
      $display("checked %0d result items: %0d out of range, %0d dead end",
               tracker.checked, tracker.range_seen, tracker.dead_seen);
      if (tracker.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/lxu_pkg.sv
rtl/core/lxu_if.sv
rtl/core/lxu_csr.sv
rtl/core/lxu_ctrl.sv
rtl/core/lxu_dp.sv
rtl/core/linear_extension_unrank_unit.sv
rtl/core/lxu_checker.sv
bench/testbench.sv
